/* sv/assert_macros.svh */
// Assertion macros shared by the handle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define RHT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also holds during reset.
`define RHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* sv/rht_pkg.sv */
// Types and constants of the refcounted handle table.
package rht_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int HANDLE_W        = 32;
   localparam int LEN_W           = 32;
   localparam int ATTR_W          = 32;
   localparam int USES_W          = 16;
   localparam int STATUS_W        = 2;

   localparam logic [USES_W-1:0] USES_MAX    = '1;
   localparam logic [ATTR_W-1:0] ATTR_RESET  = ATTR_W'(1);

   localparam logic MODE_REGISTER   = 1'b0;
   localparam logic MODE_UNREGISTER = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BADPARM = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    length;
      logic [ATTR_W-1:0]   attribute;
      logic [USES_W-1:0]   uses;
   } entry_type;

   // sequencer -> match unit
   typedef struct packed {
      logic clear;
      logic beat_vld;
   } match_ctl_type;

   // match unit -> sequencer
   typedef struct packed {
      logic hit;
      logic free_found;
   } match_stat_type;

endpackage

/* sv/refcounted_handle_table.sv */
// Refcounted handle table: top level with request sequencer, entry memory and result register.
//
// Keeps up to TABLE_DEPTH handles, each with a length, an attribute word and a
// 16-bit use count (saturating). A register beat (mode 0) raises the count of
// a live entry with the same handle, or takes the first free slot below the
// high-water mark, or appends at the mark; a full table answers status 2. A
// register beat with an attribute other than zero or csr_wdata's last value
// (reset 1), or with a negative handle, answers status 1 and changes nothing.
// An unregister beat (mode 1) lowers the count of the first live match and
// returns its length and attribute, or zeros with found 0. When the top entry
// drops to zero uses the mark falls to one past the last live entry below it, or to 1 if none is.
// Timing: every entry below the mark is read through the one read port of the
// entry memory, one per cycle, stopping at a match; a rejected register beat
// skips the scan. The next request is taken the cycle after the result is
// loaded, and req_stall is high from accept until the result goes into the
// output register. The result waits there for rsp_stall to drop while the
// next request is already taken.
// No clearing pass after reset: entries at or above the mark are never read,
// and the mark only grows by writing the slot it uncovers.
`include "assert_macros.svh"

module refcounted_handle_table #(
   parameter int TABLE_DEPTH = rht_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic [rht_pkg::ATTR_W-1:0]          csr_wdata,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic signed [rht_pkg::HANDLE_W-1:0] req_handle,
   input  logic [rht_pkg::LEN_W-1:0]           req_length,
   input  logic [rht_pkg::ATTR_W-1:0]          req_attribute,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rht_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_found,
   output logic [rht_pkg::LEN_W-1:0]           rsp_length_out,
   output logic [rht_pkg::ATTR_W-1:0]          rsp_attribute_out
);
   import rht_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // configuration register
   logic [ATTR_W-1:0]   accepted_attr_ff;

   // sequencer state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                beat_vld_ff, beat_vld_in;
   logic [IDX_W-1:0]    beat_idx_ff, beat_idx_in;
   logic [CNT_W-1:0]    high_water_ff, high_water_in;

   // captured request beat
   logic                mode_ff, mode_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic                bad_ff, bad_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [LEN_W-1:0]    rsp_length_ff, rsp_length_in;
   logic [ATTR_W-1:0]   rsp_attr_ff, rsp_attr_in;

   // memory and match unit hookup
   logic                ram_we, ram_re;
   logic [IDX_W-1:0]    ram_waddr, ram_raddr;
   entry_type           ram_wdata, ram_rdata;
   match_ctl_type       mctl;
   match_stat_type      mstat;
   logic                hit_now;
   logic [IDX_W-1:0]    hit_idx, free_idx, last_live;
   entry_type           hit_entry;

   logic                req_acc;
   logic                out_free;
   logic                issue;
   logic [USES_W-1:0]   uses_dec;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign uses_dec  = hit_entry.uses - USES_W'(1);

   rht_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_entries (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rht_match #(
      .DEPTH (TABLE_DEPTH)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mctl),
      .beat_idx  (beat_idx_ff),
      .beat_data (ram_rdata),
      .key       (handle_ff),
      .hit_now   (hit_now),
      .stat      (mstat),
      .hit_idx   (hit_idx),
      .hit_entry (hit_entry),
      .free_idx  (free_idx),
      .last_live (last_live)
   );

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      beat_idx_in   = beat_idx_ff;
      high_water_in = high_water_ff;
      mode_in       = mode_ff;
      handle_in     = handle_ff;
      length_in     = length_ff;
      attr_in       = attr_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      rsp_attr_in   = rsp_attr_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      mctl          = '0;
      issue         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               mode_in   = req_mode;
               handle_in = req_handle;
               length_in = req_length;
               attr_in   = req_attribute;
               // attribute check first, then sign of the handle
               bad_in    = (req_mode == MODE_REGISTER) &&
                           (((req_attribute != '0) && (req_attribute != accepted_attr_ff)) ||
                            req_handle[HANDLE_W-1]);
               addr_in   = '0;
               mctl.clear = 1'b1;
               state_in  = bad_in ? ST_FIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            mctl.beat_vld = beat_vld_ff;
            // one read per cycle through the live region, stop at the first match
            issue = (addr_ff < high_water_ff) && !mstat.hit && !hit_now;
            if (issue) begin
               addr_in     = addr_ff + CNT_W'(1);
               beat_idx_in = addr_ff[IDX_W-1:0];
            end
            if (mstat.hit || ((addr_ff == high_water_ff) && !beat_vld_ff)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_found_in  = 1'b0;
               rsp_length_in = '0;
               rsp_attr_in   = '0;
               state_in      = ST_IDLE;
               if (bad_ff) begin
                  rsp_status_in = STATUS_BADPARM;
               end else if (mode_ff == MODE_REGISTER) begin
                  if (mstat.hit) begin
                     // live handle: bump count, fill attribute only if it was zero
                     rsp_found_in        = 1'b1;
                     ram_we              = 1'b1;
                     ram_waddr           = hit_idx;
                     ram_wdata           = hit_entry;
                     if (hit_entry.attribute == '0) begin
                        ram_wdata.attribute = attr_ff;
                     end
                     if (hit_entry.uses != USES_MAX) begin
                        ram_wdata.uses = hit_entry.uses + USES_W'(1);
                     end
                  end else begin
                     ram_wdata.handle    = handle_ff;
                     ram_wdata.length    = length_ff;
                     ram_wdata.attribute = attr_ff;
                     ram_wdata.uses      = USES_W'(1);
                     if (mstat.free_found) begin
                        ram_we    = 1'b1;
                        ram_waddr = free_idx;
                     end else if (high_water_ff == DEPTH_CNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        // append at the mark
                        ram_we        = 1'b1;
                        ram_waddr     = high_water_ff[IDX_W-1:0];
                        high_water_in = high_water_ff + CNT_W'(1);
                     end
                  end
               end else begin
                  if (mstat.hit) begin
                     rsp_found_in   = 1'b1;
                     rsp_length_in  = hit_entry.length;
                     rsp_attr_in    = hit_entry.attribute;
                     ram_we         = 1'b1;
                     ram_waddr      = hit_idx;
                     ram_wdata      = hit_entry;
                     ram_wdata.uses = uses_dec;
                     // top entry emptied: pull the mark down
                     if (((CNT_W'(hit_idx) + CNT_W'(1)) == high_water_ff) &&
                         (uses_dec == '0)) begin
                        high_water_in = CNT_W'(last_live) + CNT_W'(1);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      beat_vld_in = issue;
   end

   assign ram_re    = issue;
   assign ram_raddr = addr_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         beat_vld_ff      <= 1'b0;
         high_water_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         accepted_attr_ff <= ATTR_RESET;
      end else begin
         state_ff      <= state_in;
         beat_vld_ff   <= beat_vld_in;
         high_water_ff <= high_water_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            accepted_attr_ff <= csr_wdata;
         end
      end
      addr_ff       <= addr_in;
      beat_idx_ff   <= beat_idx_in;
      mode_ff       <= mode_in;
      handle_ff     <= handle_in;
      length_ff     <= length_in;
      attr_ff       <= attr_in;
      bad_ff        <= bad_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
      rsp_attr_ff   <= rsp_attr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_length_out    = rsp_length_ff;
   assign rsp_attribute_out = rsp_attr_ff;

   `RHT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid_ff && (state_ff == ST_IDLE)), "not idle after reset")
   `RHT_ASSERT(a_mark_bound, clock, reset, high_water_ff <= DEPTH_CNT, "high-water mark past table depth")
   `RHT_ASSERT(a_write_at_fin, clock, reset, ram_we |-> ((state_ff == ST_FIN) && out_free), "entry write outside result load")
   `RHT_ASSERT(a_busy_after_acc, clock, reset, req_acc |=> (state_ff != ST_IDLE), "sequencer idle right after accept")

endmodule

/* sv/rht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/rht_match.sv */
// Shared compare unit: checks one entry per beat and tracks hit, free slot and last live.
`include "assert_macros.svh"

module rht_match #(
   parameter int DEPTH = rht_pkg::TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rht_pkg::match_ctl_type        ctl,
   input  logic [$clog2(DEPTH)-1:0]      beat_idx,
   input  rht_pkg::entry_type            beat_data,
   input  logic [rht_pkg::HANDLE_W-1:0]  key,
   output logic                          hit_now,
   output rht_pkg::match_stat_type       stat,
   output logic [$clog2(DEPTH)-1:0]      hit_idx,
   output rht_pkg::entry_type            hit_entry,
   output logic [$clog2(DEPTH)-1:0]      free_idx,
   output logic [$clog2(DEPTH)-1:0]      last_live
);
   import rht_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   match_stat_type   stat_ff, stat_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type        hit_entry_ff, hit_entry_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] last_live_ff, last_live_in;
   logic             live;
   logic             take;

   assign live    = (beat_data.uses != '0);
   assign take    = ctl.beat_vld && !stat_ff.hit;
   assign hit_now = take && live && (beat_data.handle == key);

   always_comb begin
      stat_in      = stat_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      free_idx_in  = free_idx_ff;
      last_live_in = last_live_ff;
      if (ctl.clear) begin
         stat_in      = '0;
         last_live_in = '0;
      end else if (take) begin
         if (hit_now) begin
            stat_in.hit  = 1'b1;
            hit_idx_in   = beat_idx;
            hit_entry_in = beat_data;
         end else if (live) begin
            last_live_in = beat_idx;
         end else if (!stat_ff.free_found) begin
            stat_in.free_found = 1'b1;
            free_idx_in        = beat_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff      <= '0;
         last_live_ff <= '0;
      end else begin
         stat_ff      <= stat_in;
         last_live_ff <= last_live_in;
      end
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_idx_ff  <= free_idx_in;
   end

   assign stat      = stat_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_entry = hit_entry_ff;
   assign free_idx  = free_idx_ff;
   assign last_live = last_live_ff;

   // once found, a hit stays until the next request clears it
   `RHT_ASSERT(a_hit_sticky, clock, reset, (stat_ff.hit && !ctl.clear) |=> stat_ff.hit, "hit lost mid-request")

endmodule

/* tb/handle_ledger_pkg.sv */
// Scoreboard for the handle table: shadow table, reply prediction and reply checking.
package handle_ledger_pkg;
   import rht_pkg::*;

   localparam int LEDGER_DEPTH = TABLE_DEPTH_DEF;

   typedef struct {
      status_type        status;
      logic              found;
      logic [LEN_W-1:0]  length_out;
      logic [ATTR_W-1:0] attribute_out;
   } reply_type;

   class handle_ledger;
      logic [HANDLE_W-1:0] slot_handle [LEDGER_DEPTH];
      logic [LEN_W-1:0]    slot_length [LEDGER_DEPTH];
      logic [ATTR_W-1:0]   slot_attr   [LEDGER_DEPTH];
      logic [USES_W-1:0]   slot_uses   [LEDGER_DEPTH];
      int unsigned         mark;
      logic [ATTR_W-1:0]   attr_ok;
      reply_type           replies [$];
      int unsigned         errors;
      int unsigned         n_register, n_unregister, n_found, n_full, n_badparm;

      function new();
         for (int k = 0; k < LEDGER_DEPTH; k++) begin
            slot_handle[k] = '0;
            slot_length[k] = '0;
            slot_attr[k]   = '0;
            slot_uses[k]   = '0;
         end
         mark = 0;
         attr_ok = ATTR_RESET;
         errors = 0;
         n_register = 0;
         n_unregister = 0;
         n_found = 0;
         n_full = 0;
         n_badparm = 0;
      endfunction

      function void set_accepted(logic [ATTR_W-1:0] v);
         attr_ok = v;
      endfunction

      function int unsigned pending();
         return replies.size();
      endfunction

      // Apply one accepted request to the shadow table and queue its reply.
      function void note_request(logic mode, logic [HANDLE_W-1:0] h,
                                 logic [LEN_W-1:0] len, logic [ATTR_W-1:0] attr);
         reply_type   r;
         int unsigned i, top, last_live;
         bit          hit;
         r.status = STATUS_OK;
         r.found = 1'b0;
         r.length_out = '0;
         r.attribute_out = '0;
         top = (mark > LEDGER_DEPTH) ? LEDGER_DEPTH : mark;
         if (mode == MODE_REGISTER) begin
            n_register++;
            if (attr != '0 && attr != attr_ok) begin
               r.status = STATUS_BADPARM;
            end else if (h[HANDLE_W-1]) begin
               r.status = STATUS_BADPARM;
            end else begin
               hit = 1'b0;
               for (i = 0; i < top; i++) begin
                  if (slot_uses[i] != '0 && slot_handle[i] == h) begin
                     if (slot_attr[i] == '0) slot_attr[i] = attr;
                     if (slot_uses[i] != USES_MAX) slot_uses[i] = slot_uses[i] + 1'b1;
                     r.found = 1'b1;
                     hit = 1'b1;
                     break;
                  end
               end
               if (!hit) begin
                  for (i = 0; i < top; i++) begin
                     if (slot_uses[i] == '0) break;
                  end
                  if (i == top && top >= LEDGER_DEPTH) begin
                     r.status = STATUS_FULL;
                  end else begin
                     if (i == top) mark = top + 1;
                     slot_handle[i] = h;
                     slot_length[i] = len;
                     slot_attr[i]   = attr;
                     slot_uses[i]   = USES_W'(1);
                  end
               end
            end
         end else begin
            n_unregister++;
            last_live = 0;
            for (i = 0; i < top; i++) begin
               if (slot_uses[i] == '0) continue;
               if (slot_handle[i] == h) begin
                  slot_uses[i] = slot_uses[i] - 1'b1;
                  r.found = 1'b1;
                  r.length_out = slot_length[i];
                  r.attribute_out = slot_attr[i];
                  if (i + 1 == top && slot_uses[i] == '0) mark = last_live + 1;
                  break;
               end
               last_live = i;
            end
         end
         if (r.found) n_found++;
         if (r.status == STATUS_FULL) n_full++;
         if (r.status == STATUS_BADPARM) n_badparm++;
         replies.push_back(r);
      endfunction

      // Compare one accepted reply beat with the oldest prediction.
      function void check_response(logic [STATUS_W-1:0] st, logic fd,
                                   logic [LEN_W-1:0] lo, logic [ATTR_W-1:0] ao);
         reply_type e;
         if (replies.size() == 0) begin
            errors++;
            $display("%0t: reply with none expected: expected nothing, actual status=%0d found=%0b length=%h attribute=%h",
                     $time, st, fd, lo, ao);
            return;
         end
         e = replies.pop_front();
         if (st !== e.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
         end
         if (fd !== e.found) begin
            errors++;
            $display("%0t: found mismatch: expected %0b, actual %0b", $time, e.found, fd);
         end
         if (lo !== e.length_out) begin
            errors++;
            $display("%0t: length_out mismatch: expected %h, actual %h", $time, e.length_out, lo);
         end
         if (ao !== e.attribute_out) begin
            errors++;
            $display("%0t: attribute_out mismatch: expected %h, actual %h",
                     $time, e.attribute_out, ao);
         end
      endfunction
   endclass

endpackage

/* tb/tb_refcounted_handle_table.sv */
// Self-checking testbench for the refcounted handle table.
module tb_refcounted_handle_table;
   import rht_pkg::*;
   import handle_ledger_pkg::*;

   // About 600 beats, each at most a full-table scan plus idle gaps on both
   // sides, plus one long reply hold; this is several times that.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned HIT_REPS    = 10;      // repeated registers of one handle
   localparam int unsigned FILL_BASE   = 5000;
   localparam int unsigned FILL_COUNT  = 266;     // more than the table holds

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [ATTR_W-1:0]          csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_mode = MODE_REGISTER;
   logic signed [HANDLE_W-1:0] req_handle = '0;
   logic [LEN_W-1:0]           req_length = '0;
   logic [ATTR_W-1:0]          req_attribute = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_found;
   logic [LEN_W-1:0]           rsp_length_out;
   logic [ATTR_W-1:0]          rsp_attribute_out;

   handle_ledger ledger;
   bit           idle_on = 1'b1;       // random gaps on both sides when set
   int unsigned  long_hold_cycles = 0; // one-shot request for a long rsp_stall
   int unsigned  cycle_count = 0;
   int unsigned  settings_used = 0;

   refcounted_handle_table DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_handle        (req_handle),
      .req_length        (req_length),
      .req_attribute     (req_attribute),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_length_out    (rsp_length_out),
      .rsp_attribute_out (rsp_attribute_out)
   );

   // 12-unit clock period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_refcounted_handle_table: FAIL");
         $finish;
      end
   end

   // Reply monitor. Sampling at the edge sees pre-edge values, i.e. exactly
   // what the block saw when deciding the beat moved.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_response(rsp_status, rsp_found, rsp_length_out, rsp_attribute_out);
   end

   // Reply-side pacing, its own process. Per reply beat it may draw a random
   // stall; half the time the stall is held until a reply is actually waiting
   // so the gap lands on a presented result. A long hold requested by the main
   // sequence is counted out here while the sender keeps offering.
   initial begin : rsp_pacing
      int unsigned hold;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_cycles != 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end else begin
            hold = idle_on ? $urandom_range(0, 4) : 0;
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               if ($urandom_range(0, 1) == 1)
                  do @(posedge clock); while (!rsp_valid);
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // One request beat. Called at a rising edge; returns at the edge that
   // accepted it, leaving req_valid high so a back-to-back beat needs no
   // second assignment in the same step.
   task automatic send_beat(input logic mode, input logic [HANDLE_W-1:0] h,
                            input logic [LEN_W-1:0] len, input logic [ATTR_W-1:0] attr);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_handle    <= h;
      req_length    <= len;
      req_attribute <= attr;
      do @(posedge clock); while (req_stall);
      ledger.note_request(mode, h, len, attr);
   endtask

   // Sender pause: drop valid and wait until every predicted reply has come.
   task automatic wait_replies_done();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Change the accepted attribute only with the block idle.
   task automatic begin_setting(input logic [ATTR_W-1:0] v, input bit idle);
      wait_replies_done();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      ledger.set_accepted(v);
      idle_on = idle;
      settings_used++;
   endtask

   // Random traffic over a small handle pool so hits and holes are common;
   // a few beats carry arbitrary 32-bit handles (negative half the time).
   task automatic run_random_beats(input int unsigned count, input int unsigned base,
                                   input int unsigned pool);
      logic              mode;
      logic [HANDLE_W-1:0] h;
      logic [ATTR_W-1:0] attr;
      int unsigned       pick;
      repeat (count) begin
         mode = ($urandom_range(0, 1) == 1) ? MODE_UNREGISTER : MODE_REGISTER;
         pick = $urandom_range(0, 19);
         h = (pick < 17) ? HANDLE_W'(base + $urandom_range(0, pool - 1)) : $urandom;
         pick = $urandom_range(0, 9);
         if (pick < 4)      attr = '0;
         else if (pick < 8) attr = ledger.attr_ok;
         else               attr = $urandom;
         send_beat(mode, h, $urandom, attr);
      end
   endtask

   initial begin : main_seq
      logic [ATTR_W-1:0] rnd_cfg;
      logic [ATTR_W-1:0] fill_attr;
      ledger = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset attribute setting (1), table starts empty.
      send_beat(MODE_UNREGISTER, 32'd0, 32'd0, 32'd0);                  // miss on empty table
      send_beat(MODE_REGISTER, 32'd0, 32'd0, 32'd0);                    // append, attr zero
      send_beat(MODE_REGISTER, 32'd0, 32'hFFFF_FFFF, 32'd1);            // hit, attr 0 -> 1
      send_beat(MODE_REGISTER, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1);    // largest handle
      send_beat(MODE_REGISTER, 32'd3, 32'hAAAA_5555, 32'd2);            // bad attribute
      send_beat(MODE_REGISTER, 32'h8000_0000, 32'd9, 32'd0);            // negative handle
      send_beat(MODE_REGISTER, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFFF);    // both bad
      send_beat(MODE_UNREGISTER, 32'hFFFF_FFFF, 32'd0, 32'd0);          // negative lookup
      send_beat(MODE_UNREGISTER, 32'h8000_0000, 32'd0, 32'd0);
      send_beat(MODE_UNREGISTER, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // fields ignored
      send_beat(MODE_UNREGISTER, 32'd0, 32'd0, 32'd0);                  // hole at slot 0
      send_beat(MODE_REGISTER, 32'd55, 32'h1234_5678, 32'd0);           // reuses the hole
      send_beat(MODE_REGISTER, 32'd55, 32'd0, 32'd1);                   // attr replaced
      send_beat(MODE_REGISTER, 32'd55, 32'd7, 32'd0);                   // attr kept
      send_beat(MODE_UNREGISTER, 32'h7FFF_FFFF, 32'd0, 32'd0);          // top drops, mark shrinks
      send_beat(MODE_REGISTER, 32'd66, 32'h0F0F_F0F0, 32'd1);           // append again
      repeat (3) send_beat(MODE_UNREGISTER, 32'd55, 32'd0, 32'd0);      // slot 0 to zero
      send_beat(MODE_UNREGISTER, 32'd66, 32'd0, 32'd0);                 // mark falls, none live
      send_beat(MODE_UNREGISTER, 32'd66, 32'd0, 32'd0);                 // now a miss

      // Repeated hits: one handle registered several times, then released one
      // more time than registered so the last release misses. Mark stays at 1;
      // no idling on either side.
      idle_on = 1'b0;
      repeat (HIT_REPS) send_beat(MODE_REGISTER, 32'd42, 32'h00C0_FFEE, 32'd1);
      repeat (HIT_REPS + 1) send_beat(MODE_UNREGISTER, 32'd42, 32'd0, 32'd0);

      // Highest attribute setting, random gaps.
      begin_setting(32'hFFFF_FFFF, 1'b1);
      run_random_beats(60, 100, 12);

      // Arbitrary setting; the reply side holds off long enough for the block
      // to back up and stall the sender.
      rnd_cfg = $urandom;
      if (rnd_cfg == '0 || rnd_cfg == 32'd1) rnd_cfg = 32'h1234_5679;
      begin_setting(rnd_cfg, 1'b1);
      long_hold_cycles = LONG_HOLD;
      run_random_beats(60, 200, 24);

      // Lowest setting, back-to-back stretch with no idling on either side.
      begin_setting(32'd1, 1'b0);
      run_random_beats(50, 300, 8);

      // Fill the table with fresh handles until it reports full, churn it,
      // then release from the top down so the mark walks back.
      begin_setting(32'd2, 1'b1);
      for (int k = 0; k < FILL_COUNT; k++) begin
         fill_attr = ($urandom_range(0, 15) == 0) ? $urandom :
                     (($urandom_range(0, 1) == 1) ? 32'd2 : 32'd0);
         send_beat(MODE_REGISTER, HANDLE_W'(FILL_BASE + k), $urandom, fill_attr);
      end
      run_random_beats(30, FILL_BASE, FILL_COUNT);
      for (int k = FILL_COUNT - 1; k >= FILL_COUNT - 80; k--)
         send_beat(MODE_UNREGISTER, HANDLE_W'(FILL_BASE + k), $urandom, $urandom);

      // Drain, then keep the clock running for stray replies.
      wait_replies_done();
      repeat (TABLE_DEPTH_DEF + 8) @(posedge clock);

      $display("Covered %0d register and %0d unregister requests under %0d attribute settings",
               ledger.n_register, ledger.n_unregister, settings_used + 1);
      $display("Replies: %0d matched handles, %0d bad-parameter, %0d table-full",
               ledger.n_found, ledger.n_badparm, ledger.n_full);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("tb_refcounted_handle_table: PASS");
      end else begin
         $display("tb_refcounted_handle_table: FAIL");
      end
      $finish;
   end

endmodule

/* refcounted_handle_table.f */
+incdir+sv
sv/rht_pkg.sv
sv/rht_ram.sv
sv/rht_match.sv
sv/refcounted_handle_table.sv
tb/handle_ledger_pkg.sv
tb/tb_refcounted_handle_table.sv
